// File: sv/cfnsa_pkg.sv
// Package for the cover-fit nearest scaler address block: sizes, register indexes and types.
package cfnsa_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS = 12;

  // Width of one size register as written over the configuration port.
  localparam int DIM_W = 13;

  // Width of the configuration register index and data.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Fill color after reset, ARGB8888.
  localparam logic [31:0] FILL_RESET = 32'hff496b83;

  // Cycles the derived scale values need to settle after reset or a write.
  localparam int SETTLE_CYCLES = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DST_WIDTH    = 3'd0,
    CFG_DST_HEIGHT   = 3'd1,
    CFG_SRC_WIDTH    = 3'd2,
    CFG_SRC_HEIGHT   = 3'd3,
    CFG_IMAGE_LOADED = 3'd4,
    CFG_FILL_COLOR   = 3'd5
  } cfg_idx_e;

  // Status that the configuration unit hands to the datapath.
  typedef struct packed {
    logic busy;
    logic image_loaded;
  } cfg_stat_t;

endpackage

// File: sv/cfnsa_cfg.sv
// Configuration registers and the registered chain that derives the scale and crop offsets.
module cfnsa_cfg #(
  parameter int COORD_BITS = cfnsa_pkg::COORD_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [cfnsa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cfnsa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output cfnsa_pkg::cfg_stat_t                  stat_o,
  output logic [31:0]                           fill_o,
  output logic [COORD_BITS:0]                   q_o,
  output logic [COORD_BITS+1:0]                 den_o,
  output logic [2*COORD_BITS+1:0]               off_x_o,
  output logic [2*COORD_BITS+1:0]               off_y_o,
  output logic [COORD_BITS:0]                   sw_o,
  output logic [COORD_BITS:0]                   sh_o
);

  localparam int D      = COORD_BITS + 1;
  localparam int NW     = 2 * COORD_BITS + 2;
  localparam int MaxDim = 1 << COORD_BITS;
  localparam int CntW   = $clog2(cfnsa_pkg::SETTLE_CYCLES + 1);

  logic [cfnsa_pkg::DIM_W-1:0] dst_w_q, dst_h_q, src_w_q, src_h_q;
  logic                        loaded_q;
  logic [31:0]                 fill_q;
  logic [CntW-1:0]             settle_q, settle_d;

  logic [D-1:0]     dw_q, dh_q, sw_q, sh_q;
  logic [2*D-1:0]   pa_q, pb_q;
  logic [D-1:0]     p_q, q_q;
  logic [2*D-1:0]   spx_q, dqx_q, spy_q, dqy_q;
  logic [NW-1:0]    offx_q, offy_q;

  // A zero size counts as one, a size above the coordinate range as the full range.
  function automatic logic [D-1:0] clamp_dim(input logic [cfnsa_pkg::DIM_W-1:0] v);
    logic [D-1:0] r;
    if (v == '0) begin
      r = D'(1);
    end else if (32'(v) > 32'(MaxDim)) begin
      r = D'(MaxDim);
    end else begin
      r = D'(v);
    end
    return r;
  endfunction

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_w_q  <= cfnsa_pkg::DIM_W'(1);
      dst_h_q  <= cfnsa_pkg::DIM_W'(1);
      src_w_q  <= cfnsa_pkg::DIM_W'(1);
      src_h_q  <= cfnsa_pkg::DIM_W'(1);
      loaded_q <= 1'b0;
      fill_q   <= cfnsa_pkg::FILL_RESET;
    end else if (cfg_valid_i) begin
      case (cfnsa_pkg::cfg_idx_e'(cfg_index_i))
        cfnsa_pkg::CFG_DST_WIDTH:    dst_w_q  <= cfg_data_i[cfnsa_pkg::DIM_W-1:0];
        cfnsa_pkg::CFG_DST_HEIGHT:   dst_h_q  <= cfg_data_i[cfnsa_pkg::DIM_W-1:0];
        cfnsa_pkg::CFG_SRC_WIDTH:    src_w_q  <= cfg_data_i[cfnsa_pkg::DIM_W-1:0];
        cfnsa_pkg::CFG_SRC_HEIGHT:   src_h_q  <= cfg_data_i[cfnsa_pkg::DIM_W-1:0];
        cfnsa_pkg::CFG_IMAGE_LOADED: loaded_q <= cfg_data_i[0];
        cfnsa_pkg::CFG_FILL_COLOR:   fill_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Settle counter: restarts on every transfer and holds off input items until it runs out.
  always_comb begin
    if (cfg_valid_i) begin
      settle_d = CntW'(cfnsa_pkg::SETTLE_CYCLES);
    end else if (settle_q != '0) begin
      settle_d = settle_q - CntW'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= CntW'(cfnsa_pkg::SETTLE_CYCLES);
    end else begin
      settle_q <= settle_d;
    end
  end

  // Derived values, registered stage by stage: clamp, cross products, select, offset terms, subtract.
  always_ff @(posedge clk_i) begin
    // Stage one: clamped sizes.
    dw_q <= clamp_dim(dst_w_q);
    dh_q <= clamp_dim(dst_h_q);
    sw_q <= clamp_dim(src_w_q);
    sh_q <= clamp_dim(src_h_q);
    // Stage two: cross products for the ratio compare.
    pa_q <= (2*D)'(dw_q) * (2*D)'(sh_q);
    pb_q <= (2*D)'(dh_q) * (2*D)'(sw_q);
    // Stage three: the larger ratio wins; on a tie the horizontal one is used.
    if (pa_q >= pb_q) begin
      p_q <= dw_q;
      q_q <= sw_q;
    end else begin
      p_q <= dh_q;
      q_q <= sh_q;
    end
    // Stage four: terms of the centering offsets.
    spx_q <= (2*D)'(sw_q) * (2*D)'(p_q);
    dqx_q <= (2*D)'(dw_q) * (2*D)'(q_q);
    spy_q <= (2*D)'(sh_q) * (2*D)'(p_q);
    dqy_q <= (2*D)'(dh_q) * (2*D)'(q_q);
    // Stage five: offsets, never negative with the chosen scale.
    offx_q <= NW'(spx_q - dqx_q);
    offy_q <= NW'(spy_q - dqy_q);
  end

  assign stat_o.busy         = (settle_q != '0);
  assign stat_o.image_loaded = loaded_q;
  assign fill_o              = fill_q;
  assign q_o                 = q_q;
  assign den_o               = {p_q, 1'b0};
  assign off_x_o             = offx_q;
  assign off_y_o             = offy_q;
  assign sw_o                = sw_q;
  assign sh_o                = sh_q;

endmodule

// File: sv/cfnsa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the result clamped to a limit.
module cfnsa_div #(
  parameter int COORD_BITS = cfnsa_pkg::COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2*COORD_BITS+1:0]   num_i,
  input  logic [COORD_BITS+1:0]     den_i,
  input  logic [COORD_BITS:0]       lim_i,
  output logic [COORD_BITS-1:0]     idx_o
);

  localparam int C  = COORD_BITS;
  localparam int NW = 2 * COORD_BITS + 2;

  logic [NW-1:0] rem_q [0:C];
  logic [C-1:0]  quo_q [0:C];
  logic          ovf_q [0:C];
  logic [C-1:0]  idx_q;

  // First stage: a quotient of more than COORD_BITS bits is always clamped.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_i >= (NW'(den_i) << C));
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 1; j <= C; j++) begin : g_bit
    localparam int K = C - j;
    logic [NW-1:0] dsh;
    logic          ge;

    assign dsh = NW'(den_i) << K;
    assign ge  = (rem_q[j-1] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_q[j-1] - dsh) : rem_q[j-1];
        quo_q[j] <= {quo_q[j-1][C-2:0], ge};
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // Last stage: clamp to the last source column or row.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ovf_q[C] || ({1'b0, quo_q[C]} >= lim_i)) begin
        idx_q <= C'(lim_i - (C+1)'(1));
      end else begin
        idx_q <= quo_q[C];
      end
    end
  end

  assign idx_o = idx_q;

endmodule

// File: sv/cover_fit_nearest_scaler_address.sv
// Top level of the cover-fit nearest scaler address generator.
// An input passes the front stages, one divider stage per quotient bit and the row product.
// Throughput: one coordinate per clock while the input is not stalled.
// A two-entry output queue lets the pipeline keep taking input while one result waits.
// Reset: sizes 1, no image, default fill color, pipeline and queue empty.
// Input is held off after reset and after each configuration transfer while scales settle.
module cover_fit_nearest_scaler_address #(
  parameter int COORD_BITS = cfnsa_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cfnsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cfnsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Coordinate input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             out_x_i,
  input  logic [COORD_BITS-1:0]             out_y_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_BITS-1:0]             src_col_o,
  output logic [COORD_BITS-1:0]             src_row_o,
  output logic [2*COORD_BITS-1:0]           src_address_o,
  output logic                              use_fill_o,
  output logic [31:0]                       fill_value_o
);

  localparam int C  = COORD_BITS;
  localparam int D  = COORD_BITS + 1;
  localparam int NW = 2 * COORD_BITS + 2;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int DS = COORD_BITS + 2;
  localparam int N  = DS + 4;

  cfnsa_pkg::cfg_stat_t cfg_stat;
  logic [31:0]          fill;
  logic [D-1:0]         q, sw, sh;
  logic [C+1:0]         den;
  logic [NW-1:0]        off_x, off_y;

  logic          en, accept, push, pop;
  logic [N-1:0]  v_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          wpos;

  logic [C-1:0]  x0_q, y0_q;
  logic [PW-1:0] xq1_q, yq1_q;
  logic [NW-1:0] nx2_q, ny2_q;
  logic [C-1:0]  col_idx, row_idx;
  logic [PW-1:0] rowm_q;
  logic [C-1:0]  colr_q, rowr_q;

  logic [C-1:0]   new_col, new_row;
  logic [2*C-1:0] new_addr;
  logic           new_fill;
  logic [31:0]    new_fv;

  logic [C-1:0]   col_e_q  [2];
  logic [C-1:0]   row_e_q  [2];
  logic [2*C-1:0] addr_e_q [2];
  logic           fill_e_q [2];
  logic [31:0]    fv_e_q   [2];

  assign cfg_ready_o = 1'b1;

  cfnsa_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (cfg_stat),
    .fill_o     (fill),
    .q_o        (q),
    .den_o      (den),
    .off_x_o    (off_x),
    .off_y_o    (off_y),
    .sw_o       (sw),
    .sh_o       (sh)
  );

  // The whole pipeline moves together while the output queue has room.
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en || cfg_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], accept};
    end
  end

  // Front stages: capture, scale by q, add the centering offset.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= out_x_i;
      y0_q  <= out_y_i;
      xq1_q <= PW'(x0_q) * PW'(q);
      yq1_q <= PW'(y0_q) * PW'(q);
      nx2_q <= NW'({xq1_q, 1'b0}) + off_x;
      ny2_q <= NW'({yq1_q, 1'b0}) + off_y;
    end
  end

  // One divider per axis, both divided by twice the chosen display size.
  cfnsa_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div_x (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(nx2_q),
    .den_i(den),
    .lim_i(sw),
    .idx_o(col_idx)
  );

  cfnsa_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div_y (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(ny2_q),
    .den_i(den),
    .lim_i(sh),
    .idx_o(row_idx)
  );

  // Row offset product.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rowm_q <= PW'(row_idx) * PW'(sw);
      colr_q <= col_idx;
      rowr_q <= row_idx;
    end
  end

  // Final address and fill selection, written straight into the output queue.
  always_comb begin
    new_fill = !cfg_stat.image_loaded;
    if (new_fill) begin
      new_col  = '0;
      new_row  = '0;
      new_addr = '0;
      new_fv   = fill;
    end else begin
      new_col  = colr_q;
      new_row  = rowr_q;
      new_addr = (2*C)'(rowm_q + PW'(colr_q));
      new_fv   = '0;
    end
  end

  // Output queue bookkeeping.
  assign push = en && v_q[N-1];
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
    wpos = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Queue entries: the head shifts on a transfer; a new result takes the first free slot.
  always_ff @(posedge clk_i) begin
    if (push && !wpos) begin
      col_e_q[0]  <= new_col;
      row_e_q[0]  <= new_row;
      addr_e_q[0] <= new_addr;
      fill_e_q[0] <= new_fill;
      fv_e_q[0]   <= new_fv;
    end else if (pop) begin
      col_e_q[0]  <= col_e_q[1];
      row_e_q[0]  <= row_e_q[1];
      addr_e_q[0] <= addr_e_q[1];
      fill_e_q[0] <= fill_e_q[1];
      fv_e_q[0]   <= fv_e_q[1];
    end
    if (push && wpos) begin
      col_e_q[1]  <= new_col;
      row_e_q[1]  <= new_row;
      addr_e_q[1] <= new_addr;
      fill_e_q[1] <= new_fill;
      fv_e_q[1]   <= new_fv;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign src_col_o     = col_e_q[0];
  assign src_row_o     = row_e_q[0];
  assign src_address_o = addr_e_q[0];
  assign use_fill_o    = fill_e_q[0];
  assign fill_value_o  = fv_e_q[0];

  // No input transfer while the derived scale values are still settling.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !cfg_stat.busy)
    else $error("input transfer taken while configuration settles");

  // A full output queue must hold off the input side.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (in_stall_o && !push))
    else $error("output queue full but pipeline still moving");

  // The queue never overflows.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q == 2'd2 || cnt_q == 2'd1))
    else $error("output queue count out of range");

  // A fill result carries no source coordinate, a mapped result no fill color.
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && use_fill_o) |->
      (src_col_o == '0 && src_row_o == '0 && src_address_o == '0))
    else $error("fill result with nonzero source fields");

  a_map_nofill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !use_fill_o) |-> (fill_value_o == '0))
    else $error("mapped result with nonzero fill value");

endmodule
